@@ rtl/c8_pkg.sv @@
// Package for the CHIP-8 instruction core: beat structs, codes, state enum, font table.
// No dependencies.
package c8_pkg;

   typedef enum logic [1:0] {
      ACT_EXEC = 2'd0,
      ACT_LOAD = 2'd1,
      ACT_TICK = 2'd2,
      ACT_ROW  = 2'd3
   } action_type;

   typedef struct packed {
      action_type  action;
      logic [11:0] address;
      logic [7:0]  data;
      logic [7:0]  random_byte;
      logic [15:0] key_mask;
      logic [4:0]  pressed_key;
   } req_type;

   typedef struct packed {
      logic [11:0] program_counter;
      logic        draw_done;
      logic        sound_on;
      logic        bad_opcode;
      logic        key_wait;
      logic [63:0] row_pixels;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CLEAR,
      ST_FETCH_HI,
      ST_FETCH_LO,
      ST_DECODE,
      ST_DRAW_RD,
      ST_DRAW_WAIT,
      ST_DRAW_ROW,
      ST_MEM_LOOP,
      ST_MEM_WAIT,
      ST_BCD,
      ST_DONE
   } state_type;

   // controller to datapath
   typedef enum logic [3:0] {
      CMD_NONE,
      CMD_LATCH,
      CMD_CLEAR_MEM,
      CMD_FETCH_HI,
      CMD_FETCH_LO,
      CMD_EXEC,
      CMD_DRAW_RD,
      CMD_DRAW_ROW,
      CMD_MEM_STEP,
      CMD_LOAD_STEP,
      CMD_BCD_STEP,
      CMD_RESPOND
   } cmd_type;

   typedef struct packed {
      cmd_type    cmd;
      logic [3:0] count;
   } ctl_type;

   typedef enum logic [2:0] {
      CL_SIMPLE,
      CL_DRAW,
      CL_SAVE,
      CL_LOAD,
      CL_BCD
   } class_type;

   typedef struct packed {
      class_type  cls;
      logic [3:0] last;
      logic       clear_done;
   } sts_type;

   localparam logic [7:0] HEX_FONT [80] = '{
      8'hF0, 8'h90, 8'h90, 8'h90, 8'hF0, 8'h20, 8'h60, 8'h20, 8'h20, 8'h70,
      8'hF0, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h10, 8'hF0, 8'h10, 8'hF0,
      8'h90, 8'h90, 8'hF0, 8'h10, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'h10, 8'hF0,
      8'hF0, 8'h80, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h10, 8'h20, 8'h40, 8'h40,
      8'hF0, 8'h90, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h90, 8'hF0, 8'h10, 8'hF0,
      8'hF0, 8'h90, 8'hF0, 8'h90, 8'h90, 8'hE0, 8'h90, 8'hE0, 8'h90, 8'hE0,
      8'hF0, 8'h80, 8'h80, 8'h80, 8'hF0, 8'hE0, 8'h90, 8'h90, 8'h90, 8'hE0,
      8'hF0, 8'h80, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h80, 8'hF0, 8'h80, 8'h80
   };

endpackage

@@ rtl/c8_ram.sv @@
// Generic single-port RAM with registered read.
// No dependencies.
module c8_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wr_data,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) mem_ff[addr] <= wr_data;
      rd_data <= mem_ff[addr];
   end
endmodule

@@ rtl/c8_ctrl.sv @@
// Sequencer of the CHIP-8 core: clearing pass, fetch, decode, draw and memory loops.
// Depends on c8_pkg.
module c8_ctrl (
   input  logic            clock,
   input  logic            reset,
   input  logic            start,
   input  c8_pkg::action_type action,
   input  c8_pkg::sts_type sts,
   output logic            busy,
   output c8_pkg::ctl_type ctl
);
   import c8_pkg::*;

   state_type  state_ff, state_in;
   logic [3:0] cnt_ff, cnt_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      unique case (state_ff)
         ST_IDLE:
            if (start) begin
               cnt_in = '0;
               if (action == ACT_EXEC) state_in = ST_FETCH_HI;
               else state_in = ST_DONE;
            end
         ST_CLEAR:     if (sts.clear_done) state_in = ST_IDLE;
         ST_FETCH_HI:  state_in = ST_FETCH_LO;
         ST_FETCH_LO:  state_in = ST_DECODE;
         ST_DECODE: begin
            cnt_in = '0;
            unique case (sts.cls)
               CL_SIMPLE: state_in = ST_DONE;
               CL_DRAW:   state_in = (sts.last == 4'd0) ? ST_DONE : ST_DRAW_RD;
               CL_SAVE:   state_in = ST_MEM_LOOP;
               CL_LOAD:   state_in = ST_MEM_LOOP;
               CL_BCD:    state_in = ST_BCD;
               default:   state_in = ST_DONE;
            endcase
         end
         ST_DRAW_RD:   state_in = ST_DRAW_WAIT;
         ST_DRAW_WAIT: state_in = ST_DRAW_ROW;
         ST_DRAW_ROW: begin
            cnt_in = cnt_ff + 4'd1;
            state_in = (cnt_ff + 4'd1 == sts.last) ? ST_DONE : ST_DRAW_RD;
         end
         ST_MEM_LOOP: begin
            if (sts.cls == CL_LOAD) state_in = ST_MEM_WAIT;
            else begin
               cnt_in = cnt_ff + 4'd1;
               if (cnt_ff == sts.last) state_in = ST_DONE;
            end
         end
         ST_MEM_WAIT: begin
            cnt_in = cnt_ff + 4'd1;
            state_in = (cnt_ff == sts.last) ? ST_DONE : ST_MEM_LOOP;
         end
         ST_BCD: begin
            cnt_in = cnt_ff + 4'd1;
            if (cnt_ff == 4'd2) state_in = ST_DONE;
         end
         ST_DONE:      state_in = ST_IDLE;
         default:      state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      busy      = (state_ff != ST_IDLE);
      ctl.count = cnt_ff;
      ctl.cmd   = CMD_NONE;
      unique case (state_ff)
         ST_IDLE:      if (start) ctl.cmd = CMD_LATCH;
         ST_CLEAR:     ctl.cmd = CMD_CLEAR_MEM;
         ST_FETCH_HI:  ctl.cmd = CMD_FETCH_HI;
         ST_FETCH_LO:  ctl.cmd = CMD_FETCH_LO;
         ST_DECODE:    ctl.cmd = CMD_EXEC;
         ST_DRAW_RD:   ctl.cmd = CMD_DRAW_RD;
         // hold the sprite address so the row byte is still there next cycle
         ST_DRAW_WAIT: ctl.cmd = CMD_DRAW_RD;
         ST_DRAW_ROW:  ctl.cmd = CMD_DRAW_ROW;
         ST_MEM_LOOP:  ctl.cmd = CMD_MEM_STEP;
         ST_MEM_WAIT:  ctl.cmd = CMD_LOAD_STEP;
         ST_BCD:       ctl.cmd = CMD_BCD_STEP;
         ST_DONE:      ctl.cmd = CMD_RESPOND;
         default:      ctl.cmd = CMD_NONE;
      endcase
   end
endmodule

@@ rtl/c8_datapath.sv @@
// Datapath of the CHIP-8 core: memory, display, registers, stack, timers.
// Depends on c8_pkg and c8_ram.
module c8_datapath #(
   parameter int PROGRAM_BASE = 512,
   parameter int FONT_BASE    = 80,
   parameter int STACK_DEPTH  = 16
) (
   input  logic            clock,
   input  logic            reset,
   input  c8_pkg::req_type req,
   input  c8_pkg::ctl_type ctl,
   output c8_pkg::sts_type sts,
   output logic            rsp_strobe,
   output c8_pkg::rsp_type rsp
);
   import c8_pkg::*;

   localparam int SPW = $clog2(STACK_DEPTH);
   localparam logic [11:0] PB = 12'(PROGRAM_BASE);
   localparam logic [11:0] FB = 12'(FONT_BASE);
   localparam logic [SPW-1:0] SP_TOP = SPW'(STACK_DEPTH - 1);

   req_type     req_ff;
   logic [7:0]  regs_ff [16];
   logic [63:0] disp_ff [32];
   logic [11:0] stack_ff [STACK_DEPTH];
   logic [11:0] idx_ff, pc_ff;
   logic [SPW-1:0] sp_ff;
   logic [7:0]  dly_ff, snd_ff;
   logic [7:0]  ophi_ff, oplo_ff;
   logic [7:0]  dx_ff, dy_ff;
   logic        hit_ff, drew_ff, bad_ff, wait_ff;
   logic [63:0] row_ff;
   logic [12:0] clr_ff;
   logic [7:0]  bcd_ff [3];

   logic        m_we;
   logic [11:0] m_addr;
   logic [7:0]  m_wd, m_rd;

   c8_ram #(.WIDTH(8), .DEPTH(4096)) u_mem (
      .clock(clock), .wr_en(m_we), .addr(m_addr), .wr_data(m_wd), .rd_data(m_rd)
   );

   logic [3:0]  x, y, n;
   logic [7:0]  nn, vx, vy;
   logic [11:0] nnn;
   assign x   = ophi_ff[3:0];
   assign y   = oplo_ff[7:4];
   assign n   = oplo_ff[3:0];
   assign nn  = oplo_ff;
   assign nnn = {ophi_ff[3:0], oplo_ff};
   assign vx  = regs_ff[x];
   assign vy  = regs_ff[y];

   always_comb begin
      sts.clear_done = (clr_ff == 13'd4095);
      sts.last = x;
      sts.cls  = CL_SIMPLE;
      if (ophi_ff[7:4] == 4'hD) begin
         sts.cls = CL_DRAW; sts.last = n;
      end else if (ophi_ff[7:4] == 4'hF) begin
         if (nn == 8'h55) sts.cls = CL_SAVE;
         else if (nn == 8'h65) sts.cls = CL_LOAD;
         else if (nn == 8'h33) sts.cls = CL_BCD;
      end
   end

   // clearing pass writes font bytes at FONT_BASE, zero elsewhere
   logic [11:0] clr_addr, font_off;
   assign clr_addr = clr_ff[11:0];
   assign font_off = clr_addr - FB;

   // fetch: PC goes out with the accepted beat, PC + 1 in the first fetch cycle
   always_comb begin
      m_we = 1'b0; m_addr = pc_ff; m_wd = '0;
      unique case (ctl.cmd)
         CMD_CLEAR_MEM: begin
            m_we = 1'b1; m_addr = clr_addr;
            m_wd = (font_off < 12'd80) ? HEX_FONT[font_off[6:0]] : 8'h00;
         end
         CMD_LATCH: begin
            m_we   = (req.action == ACT_LOAD);
            m_addr = (req.action == ACT_EXEC) ? pc_ff : req.address;
            m_wd   = req.data;
         end
         CMD_FETCH_HI: m_addr = pc_ff + 12'd1;
         CMD_FETCH_LO: m_addr = pc_ff;
         CMD_DRAW_RD:  m_addr = idx_ff + 12'(ctl.count);
         CMD_MEM_STEP: begin
            m_addr = idx_ff + 12'(ctl.count);
            m_we   = (sts.cls == CL_SAVE);
            m_wd   = regs_ff[ctl.count];
         end
         CMD_BCD_STEP: begin
            m_we = 1'b1; m_addr = idx_ff + 12'(ctl.count);
            m_wd = bcd_ff[ctl.count[1:0]];
         end
         default: ;
      endcase
   end

   // BCD digits by compare-subtract
   logic [7:0] h_in, t_in, r1, r2;
   always_comb begin
      h_in = (vx >= 8'd200) ? 8'd2 : (vx >= 8'd100) ? 8'd1 : 8'd0;
      r1 = vx - 8'(h_in * 8'd100);
      t_in = 8'd0; r2 = r1;
      for (int k = 9; k >= 1; k--) begin
         if (r1 >= 8'(k * 10) && t_in == 8'd0) begin
            t_in = 8'(k); r2 = r1 - 8'(k * 10);
         end
      end
   end

   // sprite row XOR
   logic [4:0]  drow;
   logic [63:0] smask, drow_old;
   assign drow = 5'(dy_ff + 8'(ctl.count));
   assign drow_old = disp_ff[drow];
   always_comb begin
      logic [5:0] col;
      smask = '0;
      for (int c = 0; c < 8; c++) begin
         col = 6'(dx_ff + 8'(c));
         if (m_rd[7-c]) smask[6'd63 - col] = 1'b1;
      end
   end

   logic [12:0] sum_i;
   assign sum_i = {1'b0, idx_ff} + {5'd0, vx};
   logic [8:0] add9;
   assign add9 = {1'b0, vx} + {1'b0, vy};
   logic [11:0] pc2;
   assign pc2 = pc_ff + 12'd2;
   logic down;
   assign down = (vx < 8'd16) && req_ff.key_mask[vx[3:0]];

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
         for (int k = 0; k < 16; k++) regs_ff[k] <= '0;
         for (int k = 0; k < 32; k++) disp_ff[k] <= '0;
         idx_ff <= PB; pc_ff <= PB; sp_ff <= '0;
         dly_ff <= '0; snd_ff <= '0;
         rsp_strobe <= 1'b0;
      end else begin
         rsp_strobe <= 1'b0;
         unique case (ctl.cmd)
            CMD_CLEAR_MEM: clr_ff <= clr_ff + 13'd1;
            CMD_LATCH: begin
               req_ff <= req;
               drew_ff <= 1'b0; bad_ff <= 1'b0; wait_ff <= 1'b0; row_ff <= '0;
               if (req.action == ACT_TICK) begin
                  if (dly_ff != 0) dly_ff <= dly_ff - 8'd1;
                  if (snd_ff != 0) snd_ff <= snd_ff - 8'd1;
               end
               if (req.action == ACT_ROW) row_ff <= disp_ff[req.address[4:0]];
            end
            CMD_FETCH_HI: ophi_ff <= m_rd;
            CMD_FETCH_LO: oplo_ff <= m_rd;
            CMD_EXEC: begin
               pc_ff <= pc2;
               unique case (ophi_ff[7:4])
                  4'h0:
                     if (nnn == 12'h0E0) begin
                        for (int k = 0; k < 32; k++) disp_ff[k] <= '0;
                     end else if (nnn == 12'h0EE) begin
                        sp_ff <= (sp_ff == 0) ? SP_TOP : sp_ff - SPW'(1);
                        pc_ff <= stack_ff[(sp_ff == 0) ? SP_TOP : sp_ff - SPW'(1)];
                     end else bad_ff <= 1'b1;
                  4'h1: pc_ff <= nnn;
                  4'h2: begin
                     stack_ff[sp_ff] <= pc2;
                     sp_ff <= (sp_ff == SP_TOP) ? '0 : sp_ff + SPW'(1);
                     pc_ff <= nnn;
                  end
                  4'h3: if (vx == nn) pc_ff <= pc_ff + 12'd4;
                  4'h4: if (vx != nn) pc_ff <= pc_ff + 12'd4;
                  4'h5: if (vx == vy) pc_ff <= pc_ff + 12'd4;
                  4'h6: regs_ff[x] <= nn;
                  4'h7: regs_ff[x] <= vx + nn;
                  4'h8:
                     unique case (n)
                        4'h0: regs_ff[x] <= vy;
                        4'h1: regs_ff[x] <= vx | vy;
                        4'h2: regs_ff[x] <= vx & vy;
                        4'h3: regs_ff[x] <= vx ^ vy;
                        4'h4: begin
                           regs_ff[x] <= add9[7:0]; regs_ff[15] <= {7'd0, add9[8]};
                        end
                        4'h5: begin
                           regs_ff[x] <= vx - vy; regs_ff[15] <= {7'd0, vx >= vy};
                        end
                        4'h6: begin
                           regs_ff[x] <= vx >> 1; regs_ff[15] <= {7'd0, vx[0]};
                        end
                        4'h7: begin
                           regs_ff[x] <= vy - vx; regs_ff[15] <= {7'd0, vy >= vx};
                        end
                        4'hE: begin
                           regs_ff[x] <= vx << 1; regs_ff[15] <= {7'd0, vx[7]};
                        end
                        default: bad_ff <= 1'b1;
                     endcase
                  4'h9: if (vx != vy) pc_ff <= pc_ff + 12'd4;
                  4'hA: idx_ff <= nnn;
                  4'hB: pc_ff <= nnn + {4'd0, regs_ff[0]};
                  4'hC: regs_ff[x] <= req_ff.random_byte & nn;
                  4'hD: begin
                     dx_ff <= vx; dy_ff <= vy; hit_ff <= 1'b0; drew_ff <= 1'b1;
                     if (n == 4'd0) regs_ff[15] <= 8'd0;
                  end
                  4'hE:
                     if (nn == 8'h9E || nn == 8'hA1) begin
                        if ((nn == 8'h9E) == down) pc_ff <= pc_ff + 12'd4;
                     end else bad_ff <= 1'b1;
                  4'hF:
                     unique case (nn)
                        8'h07: regs_ff[x] <= dly_ff;
                        8'h0A:
                           if (req_ff.pressed_key < 5'd16)
                              regs_ff[x] <= {3'd0, req_ff.pressed_key};
                           else begin
                              wait_ff <= 1'b1; pc_ff <= pc_ff;
                           end
                        8'h15: dly_ff <= vx;
                        8'h18: snd_ff <= vx;
                        8'h1E: begin
                           idx_ff <= sum_i[11:0]; regs_ff[15] <= {7'd0, sum_i[12]};
                        end
                        8'h29: idx_ff <= FB + {6'd0, vx[3:0], 2'd0} + {8'd0, vx[3:0]};
                        8'h33: begin
                           bcd_ff[0] <= h_in; bcd_ff[1] <= t_in; bcd_ff[2] <= r2;
                        end
                        8'h55, 8'h65: ;
                        default: bad_ff <= 1'b1;
                     endcase
                  default: ;
               endcase
            end
            CMD_DRAW_ROW: begin
               disp_ff[drow] <= drow_old ^ smask;
               if ((drow_old & smask) != '0) hit_ff <= 1'b1;
               if (5'(ctl.count) + 5'd1 == {1'b0, n})
                  regs_ff[15] <= {7'd0, hit_ff || ((drow_old & smask) != '0)};
            end
            CMD_LOAD_STEP: regs_ff[ctl.count] <= m_rd;
            CMD_RESPOND: begin
               rsp_strobe <= 1'b1;
               rsp.program_counter <= pc_ff;
               rsp.draw_done <= drew_ff;
               rsp.sound_on <= (snd_ff != 0);
               rsp.bad_opcode <= bad_ff;
               rsp.key_wait <= wait_ff;
               rsp.row_pixels <= row_ff;
            end
            default: ;
         endcase
      end
   end
endmodule

@@ rtl/chip8_instruction_core.sv @@
// Top level of the CHIP-8 instruction core: controller plus datapath.
// Depends on c8_pkg, c8_ctrl, c8_datapath.
//
// One beat per start while busy is low; one result strobe per beat, which the
// receiver must take in that cycle. After reset a clearing pass loads the font
// and zeroes program memory; busy stays high meanwhile. Sprite draws (one
// memory byte per row), FX55 and FX65 (V0 to VX) and BCD (three digits) step
// through the single memory port.
module chip8_instruction_core #(
   parameter int PROGRAM_BASE = 512,
   parameter int FONT_BASE    = 80,
   parameter int STACK_DEPTH  = 16
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            start,
   output logic            busy,
   input  c8_pkg::req_type req_beat,
   output logic            rsp_strobe,
   output c8_pkg::rsp_type rsp_beat
);
   import c8_pkg::*;

   ctl_type ctl;
   sts_type sts;

   c8_ctrl u_ctrl (
      .clock(clock), .reset(reset), .start(start), .action(req_beat.action),
      .sts(sts), .busy(busy), .ctl(ctl)
   );

   c8_datapath #(
      .PROGRAM_BASE(PROGRAM_BASE), .FONT_BASE(FONT_BASE), .STACK_DEPTH(STACK_DEPTH)
   ) u_dp (
      .clock(clock), .reset(reset), .req(req_beat), .ctl(ctl), .sts(sts),
      .rsp_strobe(rsp_strobe), .rsp(rsp_beat)
   );

`ifndef NO_ASSERTIONS
   a_strobe_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(busy)) else $error("strobe without work");
   a_accept_resp: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy) else $error("accepted beat not taken up");
   a_no_double: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe) else $error("two strobes in a row");
`endif
endmodule
